// ===== rtl/delta_instruction_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// delta instruction decoder assertion macros
// implication checks on the rising edge, muted during reset, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef DELTA_INSTRUCTION_DECODER_CORE_MACROS_SVH
`define DELTA_INSTRUCTION_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DID_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("did: same-cycle check failed");
`define DID_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("did: next-cycle check failed");
`else
`define DID_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define DID_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/did_pkg.sv =====
// ----------------------------------------------------------------------------
// did_pkg
// shared types and constants of the delta instruction decoder
// ----------------------------------------------------------------------------
package did_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [23:0] LEN_ZERO_SUBST = 24'h010000;

    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_COPY = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SRC_MISMATCH = 3'd1,
        ST_ZERO_CMD     = 3'd2,
        ST_RANGE        = 3'd3,
        ST_SIZE         = 3'd4,
        ST_CUT          = 3'd5,
        ST_VARINT       = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_LIT  = 3'd1,
        OP_RUN  = 3'd2,
        OP_COPY = 3'd3,
        OP_TGT  = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [23:0] len;
        logic        fin;
        status_t     fstat;
    } entry_t;

endpackage

// ===== rtl/did_queue.sv =====
// ----------------------------------------------------------------------------
// did_queue
// short fifo between the parser front and the checking back
// ----------------------------------------------------------------------------
module did_queue
    import did_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         in_ready,
    input  logic         pop,
    output logic         rvalid,
    output logic [W-1:0] rdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign in_ready = (count_reg != NW'(QUEUE_DEPTH));
    assign rvalid   = (count_reg != '0);
    assign rdata    = mem[rd_ptr_reg];
    assign do_push  = push && in_ready;
    assign do_pop   = pop && rvalid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/did_front.sv =====
// ----------------------------------------------------------------------------
// did_front
// byte parser: header varints, command bytes, copy operand gathering
// ----------------------------------------------------------------------------
module did_front
    import did_pkg::*;
#(
    parameter int SIZE_BITS = 32,
    parameter int VAL_W     = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_delta_byte,
    input  logic             s_final_byte,
    input  logic [31:0]      base_size,
    input  logic             q_ready,
    output logic             q_push,
    output entry_t           q_entry,
    output logic [VAL_W-1:0] q_val
);

    localparam int SH_W = $clog2(SIZE_BITS + 8);

    typedef enum logic [5:0] {
        PH_SRC  = 6'b000001,
        PH_TGT  = 6'b000010,
        PH_CMD  = 6'b000100,
        PH_COPY = 6'b001000,
        PH_LIT  = 6'b010000,
        PH_ERR  = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    logic [SH_W-1:0]        shift_reg, shift_next;
    logic [6:0]             flags_reg, flags_next;
    logic [31:0]            off_reg, off_next;
    logic [23:0]            len_reg, len_next;
    logic [6:0]             lit_left_reg, lit_left_next;
    status_t                err_reg, err_next;

    logic                   accept;
    logic [SIZE_BITS+6:0]   wide;
    logic                   vi_ovf;
    logic [SIZE_BITS-1:0]   acc_or;
    logic [SH_W-1:0]        shift_sum, shift_sat;
    logic                   src_match;
    logic [6:0]             lowbit, flags_clr, lit_dec;
    logic [31:0]            off_upd;
    logic [23:0]            len_upd;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    // varint accumulate
    assign wide      = (SIZE_BITS + 7)'(s_delta_byte[6:0]) << shift_reg;
    assign vi_ovf    = (shift_reg >= SH_W'(SIZE_BITS)) || (wide[SIZE_BITS+6:SIZE_BITS] != '0);
    assign acc_or    = acc_reg | wide[SIZE_BITS-1:0];
    assign shift_sum = shift_reg + SH_W'(7);
    assign shift_sat = (shift_sum >= SH_W'(SIZE_BITS)) ? SH_W'(SIZE_BITS) : shift_sum;
    assign src_match = (VAL_W'(acc_or) == VAL_W'(base_size));

    // copy operand gathering
    assign lowbit    = flags_reg & (~flags_reg + 7'd1);
    assign flags_clr = flags_reg & ~lowbit;
    assign lit_dec   = lit_left_reg - 7'd1;

    always_comb begin
        off_upd = off_reg;
        len_upd = len_reg;
        for (int i = 0; i < 4; i++) begin
            if (lowbit[i]) begin
                off_upd[8*i +: 8] = off_reg[8*i +: 8] | s_delta_byte;
            end
        end
        for (int j = 0; j < 3; j++) begin
            if (lowbit[4+j]) begin
                len_upd[8*j +: 8] = len_reg[8*j +: 8] | s_delta_byte;
            end
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        shift_next    = shift_reg;
        flags_next    = flags_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        lit_left_next = lit_left_reg;
        err_next      = err_reg;
        q_push        = 1'b0;
        q_entry.op    = OP_NONE;
        q_entry.data  = '0;
        q_entry.len   = '0;
        q_entry.fin   = 1'b0;
        q_entry.fstat = ST_OK;
        q_val         = '0;
        if (accept) begin
            case (phase_reg)
                PH_SRC, PH_TGT: begin
                    if (vi_ovf) begin
                        err_next   = ST_VARINT;
                        phase_next = PH_ERR;
                    end else begin
                        acc_next   = acc_or;
                        shift_next = shift_sat;
                        if (!s_delta_byte[7]) begin
                            acc_next   = '0;
                            shift_next = '0;
                            if (phase_reg == PH_SRC) begin
                                if (src_match) begin
                                    phase_next = PH_TGT;
                                end else begin
                                    err_next   = ST_SRC_MISMATCH;
                                    phase_next = PH_ERR;
                                end
                            end else begin
                                q_push     = 1'b1;
                                q_entry.op = OP_TGT;
                                q_val      = VAL_W'(acc_or);
                                phase_next = PH_CMD;
                            end
                        end
                    end
                end
                PH_CMD: begin
                    if (s_delta_byte == 8'd0) begin
                        err_next   = ST_ZERO_CMD;
                        phase_next = PH_ERR;
                    end else if (s_delta_byte[7]) begin
                        off_next   = '0;
                        len_next   = '0;
                        flags_next = s_delta_byte[6:0];
                        if (s_delta_byte[6:0] == 7'd0) begin
                            q_push      = 1'b1;
                            q_entry.op  = OP_COPY;
                            q_entry.len = LEN_ZERO_SUBST;
                        end else begin
                            phase_next = PH_COPY;
                        end
                    end else begin
                        q_push        = 1'b1;
                        q_entry.op    = OP_RUN;
                        q_entry.data  = s_delta_byte;
                        lit_left_next = s_delta_byte[6:0];
                        phase_next    = PH_LIT;
                    end
                end
                PH_COPY: begin
                    off_next   = off_upd;
                    len_next   = len_upd;
                    flags_next = flags_clr;
                    if (flags_clr == 7'd0) begin
                        q_push      = 1'b1;
                        q_entry.op  = OP_COPY;
                        q_val       = VAL_W'(off_upd);
                        q_entry.len = (len_upd == '0) ? LEN_ZERO_SUBST : len_upd;
                        phase_next  = PH_CMD;
                    end
                end
                PH_LIT: begin
                    q_push        = 1'b1;
                    q_entry.op    = OP_LIT;
                    q_entry.data  = s_delta_byte;
                    lit_left_next = lit_dec;
                    if (lit_dec == 7'd0) begin
                        phase_next = PH_CMD;
                    end
                end
                PH_ERR: begin
                end
                default: begin
                end
            endcase
            if (s_final_byte) begin
                q_push      = 1'b1;
                q_entry.fin = 1'b1;
                if (phase_next == PH_ERR) begin
                    q_entry.fstat = err_next;
                end else if (phase_next != PH_CMD) begin
                    q_entry.fstat = ST_CUT;
                end else begin
                    q_entry.fstat = ST_OK;
                end
                phase_next    = PH_SRC;
                acc_next      = '0;
                shift_next    = '0;
                flags_next    = '0;
                off_next      = '0;
                len_next      = '0;
                lit_left_next = '0;
                err_next      = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SRC;
            acc_reg      <= '0;
            shift_reg    <= '0;
            flags_reg    <= '0;
            off_reg      <= '0;
            len_reg      <= '0;
            lit_left_reg <= '0;
            err_reg      <= ST_OK;
        end else begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            shift_reg    <= shift_next;
            flags_reg    <= flags_next;
            off_reg      <= off_next;
            len_reg      <= len_next;
            lit_left_reg <= lit_left_next;
            err_reg      <= err_next;
        end
    end

endmodule

// ===== rtl/did_back.sv =====
// ----------------------------------------------------------------------------
// did_back
// range and size checks, target accounting and the result output register
// ----------------------------------------------------------------------------
`include "delta_instruction_decoder_core_macros.svh"

module did_back
    import did_pkg::*;
#(
    parameter int SIZE_BITS = 32,
    parameter int VAL_W     = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      base_size,
    input  logic             q_valid,
    output logic             q_pop,
    input  entry_t           q_entry,
    input  logic [VAL_W-1:0] q_val,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_lit_byte,
    output logic [31:0]      m_copy_from,
    output logic [23:0]      m_copy_len,
    output logic [2:0]       m_status,
    output logic             m_last
);

    localparam int CW = (SIZE_BITS > 32) ? SIZE_BITS + 1 : 33;

    logic [SIZE_BITS-1:0] remain_reg, remain_next;
    status_t              err_reg, err_next;
    logic                 end_pend_reg, end_pend_next;
    status_t              end_status_reg, end_status_next;
    logic                 m_valid_reg, m_valid_next;
    kind_t                kind_reg, kind_next;
    logic [7:0]           lit_reg, lit_next;
    logic [31:0]          from_reg, from_next;
    logic [23:0]          len_reg, len_next;
    status_t              status_reg, status_next;
    logic                 last_reg, last_next;

    logic                 out_free;
    logic                 emit_data;
    status_t              end_st;
    logic [CW-1:0]        remain_w, len_w, byte_w, copy_end, base_w, copy_end_out;

    assign out_free     = !m_valid_reg || m_ready;
    assign q_pop        = !end_pend_reg && out_free && q_valid;
    assign remain_w     = CW'(remain_reg);
    assign len_w        = CW'(q_entry.len);
    assign byte_w       = CW'(q_entry.data);
    assign copy_end     = CW'(q_val[31:0]) + len_w;
    assign base_w       = CW'(base_size);
    assign copy_end_out = CW'(from_reg) + CW'(len_reg);

    always_comb begin
        remain_next     = remain_reg;
        err_next        = err_reg;
        end_pend_next   = end_pend_reg;
        end_status_next = end_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        kind_next       = kind_reg;
        lit_next        = lit_reg;
        from_next       = from_reg;
        len_next        = len_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        emit_data       = 1'b0;
        end_st          = ST_OK;
        if (end_pend_reg) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                kind_next     = KIND_END;
                lit_next      = '0;
                from_next     = '0;
                len_next      = '0;
                status_next   = end_status_reg;
                last_next     = 1'b1;
                end_pend_next = 1'b0;
            end
        end else if (q_pop) begin
            if (err_reg == ST_OK) begin
                case (q_entry.op)
                    OP_TGT: begin
                        remain_next = q_val[SIZE_BITS-1:0];
                    end
                    OP_RUN: begin
                        if (byte_w > remain_w) begin
                            err_next = ST_SIZE;
                        end else begin
                            remain_next = SIZE_BITS'(remain_w - byte_w);
                        end
                    end
                    OP_LIT: begin
                        emit_data = 1'b1;
                        kind_next = KIND_LIT;
                        lit_next  = q_entry.data;
                        from_next = '0;
                        len_next  = '0;
                    end
                    OP_COPY: begin
                        if (copy_end > base_w) begin
                            err_next = ST_RANGE;
                        end else if (len_w > remain_w) begin
                            err_next = ST_SIZE;
                        end else begin
                            emit_data   = 1'b1;
                            kind_next   = KIND_COPY;
                            lit_next    = '0;
                            from_next   = q_val[31:0];
                            len_next    = q_entry.len;
                            remain_next = SIZE_BITS'(remain_w - len_w);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (emit_data) begin
                m_valid_next = 1'b1;
                status_next  = ST_OK;
                last_next    = 1'b0;
            end
            if (q_entry.fin) begin
                if (err_next != ST_OK) begin
                    end_st = err_next;
                end else if (q_entry.fstat != ST_OK) begin
                    end_st = q_entry.fstat;
                end else if (remain_next != '0) begin
                    end_st = ST_SIZE;
                end else begin
                    end_st = ST_OK;
                end
                remain_next = '0;
                err_next    = ST_OK;
                if (emit_data) begin
                    end_pend_next   = 1'b1;
                    end_status_next = end_st;
                end else begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_END;
                    lit_next     = '0;
                    from_next    = '0;
                    len_next     = '0;
                    status_next  = end_st;
                    last_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg   <= '0;
            err_reg      <= ST_OK;
            end_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            remain_reg   <= remain_next;
            err_reg      <= err_next;
            end_pend_reg <= end_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_status_reg <= end_status_next;
        kind_reg       <= kind_next;
        lit_reg        <= lit_next;
        from_reg       <= from_next;
        len_reg        <= len_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_kind  = kind_reg;
    assign m_lit_byte  = lit_reg;
    assign m_copy_from = from_reg;
    assign m_copy_len  = len_reg;
    assign m_status    = status_reg;
    assign m_last      = last_reg;

    `DID_ASSERT_IMPLIES(a_pend_behind_data, aclk, aresetn, end_pend_reg, m_valid_reg && kind_reg != KIND_END)
    `DID_ASSERT_NEXT(a_pend_holds_on_stall, aclk, aresetn, end_pend_reg && !m_ready, end_pend_reg)
    `DID_ASSERT_IMPLIES(a_last_on_end_only, aclk, aresetn, m_valid_reg && last_reg, kind_reg == KIND_END)
    `DID_ASSERT_IMPLIES(a_copy_within_base, aclk, aresetn, m_valid_reg && kind_reg == KIND_COPY, copy_end_out <= base_w && len_reg != '0)

endmodule

// ===== rtl/delta_instruction_decoder_core.sv =====
// ----------------------------------------------------------------------------
// delta_instruction_decoder_core
// one delta byte per cycle while the queue has room; a result passes through the queue and the output register
// a byte that closes a literal or copy and also ends the stream gives a data result, then an end result
// synchronous active-low reset clears parser, queue, output and base_size
// ----------------------------------------------------------------------------
module delta_instruction_decoder_core
    import did_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_delta_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_lit_byte,
    output logic [31:0] m_copy_from,
    output logic [23:0] m_copy_len,
    output logic [2:0]  m_status,
    output logic        m_last
);

    localparam int VAL_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;
    localparam int QW    = $bits(entry_t) + VAL_W;

    logic [31:0]      base_size_reg, base_size_next;
    logic             fr_ready;
    logic             fr_push;
    entry_t           fr_entry;
    logic [VAL_W-1:0] fr_val;
    logic             bk_valid;
    logic             bk_pop;
    logic [QW-1:0]    bk_data;
    entry_t           bk_entry;
    logic [VAL_W-1:0] bk_val;

    assign base_size_next = cfg_wr_en ? cfg_wr_data : base_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_size_reg <= '0;
        end else begin
            base_size_reg <= base_size_next;
        end
    end

    did_front #(
        .SIZE_BITS (SIZE_BITS),
        .VAL_W     (VAL_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_delta_byte (s_delta_byte),
        .s_final_byte (s_final_byte),
        .base_size    (base_size_reg),
        .q_ready      (fr_ready),
        .q_push       (fr_push),
        .q_entry      (fr_entry),
        .q_val        (fr_val)
    );

    did_queue #(
        .W (QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fr_push),
        .wdata    ({fr_entry, fr_val}),
        .in_ready (fr_ready),
        .pop      (bk_pop),
        .rvalid   (bk_valid),
        .rdata    (bk_data)
    );

    assign bk_entry = entry_t'(bk_data[QW-1:VAL_W]);
    assign bk_val   = bk_data[VAL_W-1:0];

    did_back #(
        .SIZE_BITS (SIZE_BITS),
        .VAL_W     (VAL_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .base_size   (base_size_reg),
        .q_valid     (bk_valid),
        .q_pop       (bk_pop),
        .q_entry     (bk_entry),
        .q_val       (bk_val),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_lit_byte  (m_lit_byte),
        .m_copy_from (m_copy_from),
        .m_copy_len  (m_copy_len),
        .m_status    (m_status),
        .m_last      (m_last)
    );

endmodule
